>>> src/rit_pkg.sv
// shared types, constants and helpers of the romberg integration tableau
package rit_pkg;

	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned EST_W    = 32;
	localparam int unsigned SUM_W    = 48;
	localparam int unsigned WIDTH_W  = 31;
	localparam int unsigned IDX_W    = 4;
	localparam int unsigned TDATA_W  = 40;

	// configuration register indexes
	localparam logic REG_INTERVAL_WIDTH = 1'b0;
	localparam logic REG_LEVEL_COUNT    = 1'b1;

	// one finished level handed from the front to the back
	typedef struct packed {
		logic signed [SUM_W-1:0]   sum;
		logic [WIDTH_W-1:0]        step;
		logic [IDX_W-1:0]          level;
		logic                      done;
	} rit_job_t;

	// q0.32 reciprocal of 4^j-1, rounded to nearest
	function automatic logic [30:0] recip_q32(input logic [IDX_W-1:0] j);
		logic [30:0] r;
		unique case (j)
			4'd1:    r = 31'd1431655765;
			4'd2:    r = 31'd286331153;
			4'd3:    r = 31'd68174084;
			4'd4:    r = 31'd16843009;
			4'd5:    r = 31'd4198404;
			4'd6:    r = 31'd1048832;
			4'd7:    r = 31'd262160;
			4'd8:    r = 31'd65537;
			4'd9:    r = 31'd16384;
			4'd10:   r = 31'd4096;
			4'd11:   r = 31'd1024;
			4'd12:   r = 31'd256;
			default: r = 31'd0;
		endcase
		return r;
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [EST_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [EST_W-1:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[EST_W-1:0];
		return r;
	endfunction

endpackage

>>> src/rit_front.sv
// front end: configuration registers, sample accumulation and level detection
module rit_front
	import rit_pkg::*;
#(
	parameter int unsigned MAX_LEVELS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	input  logic                       cfg_index,
	input  logic [WIDTH_W-1:0]         cfg_data,
	input  logic                       sample_valid,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       queue_full,
	output logic                       sample_ready,
	output logic                       push,
	output rit_job_t                   push_job
);

	localparam int unsigned CW = MAX_LEVELS;

	logic [WIDTH_W-1:0]      interval_width_q;
	logic [IDX_W-1:0]        level_count_q;
	logic [WIDTH_W-1:0]      step_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [IDX_W-1:0]        level_q;
	logic [CW-1:0]           cnt_q;

	logic                    accept;
	logic signed [SUM_W-1:0] sum_next;
	logic [CW-1:0]           cnt_next;
	logic [CW-1:0]           target;
	logic [IDX_W-1:0]        levels_eff;
	logic                    level_end;
	logic                    run_done;

	assign sample_ready = !queue_full;
	assign accept       = sample_valid && sample_ready;
	assign sum_next     = sum_q + SUM_W'(sample);
	assign cnt_next     = cnt_q + CW'(1);
	assign target       = CW'(1) << (level_q - IDX_W'(1));

	// effective level count, clamped to one and to the maximum
	always_comb begin
		if (level_count_q == '0)
			levels_eff = IDX_W'(1);
		else if (level_count_q > IDX_W'(MAX_LEVELS))
			levels_eff = IDX_W'(MAX_LEVELS);
		else
			levels_eff = level_count_q;
	end

	// level completion and the request to the back end
	always_comb begin
		level_end = 1'b0;
		if (level_q == '0)
			level_end = (cnt_q != '0);
		else
			level_end = (cnt_next == target);
		run_done      = (level_q != '0) && (level_q >= levels_eff);
		push          = accept && level_end;
		push_job.sum  = sum_next;
		push_job.step = step_q;
		push_job.level = level_q;
		push_job.done = run_done;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_width_q <= WIDTH_W'(65536);
			level_count_q    <= IDX_W'(8);
		end else if (cfg_valid) begin
			if (cfg_index == REG_INTERVAL_WIDTH)
				interval_width_q <= cfg_data;
			else if (cfg_index == REG_LEVEL_COUNT)
				level_count_q <= cfg_data[IDX_W-1:0];
		end
	end

	// accumulation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			sum_q   <= '0;
			level_q <= '0;
			cnt_q   <= '0;
		end else if (accept) begin
			if (level_q == '0 && cnt_q == '0) begin
				step_q <= interval_width_q;
				sum_q  <= SUM_W'(sample);
				cnt_q  <= CW'(1);
			end else if (level_end) begin
				sum_q   <= '0;
				cnt_q   <= '0;
				level_q <= run_done ? '0 : level_q + IDX_W'(1);
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
			end
		end
	end

endmodule

>>> src/rit_queue.sv
// two-entry queue of finished levels between front and back
module rit_queue
	import rit_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  rit_job_t push_job,
	input  logic     pop,
	output rit_job_t pop_job,
	output logic     full,
	output logic     empty
);

	rit_job_t   slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign pop_job = slot_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full)
			slot_q[wr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push && !full)
				wr_q <= !wr_q;
			if (pop && !empty)
				rd_q <= !rd_q;
			count_q <= count_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

endmodule

>>> src/rit_back.sv
// back end: trapezoid entry, richardson extrapolation and output register
module rit_back
	import rit_pkg::*;
#(
	parameter int unsigned MAX_LEVELS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    queue_empty,
	input  rit_job_t                job,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [IDX_W-1:0]        row_index,
	output logic [IDX_W-1:0]        column_index,
	output logic signed [EST_W-1:0] estimate,
	output logic                    last_of_row,
	output logic                    all_done
);

	localparam int unsigned RW    = (MAX_LEVELS + 1 > 1) ? $clog2(MAX_LEVELS + 1) : 1;
	localparam int unsigned FULLW = 80;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_MUL_LO = 10'b0000000010,
		ST_MUL_HI = 10'b0000000100,
		ST_ADD    = 10'b0000001000,
		ST_SHIFT  = 10'b0000010000,
		ST_ROW0   = 10'b0000100000,
		ST_EMIT   = 10'b0001000000,
		ST_DIFF   = 10'b0010000000,
		ST_RMUL   = 10'b0100000000,
		ST_RADD   = 10'b1000000000
	} back_state_t;

	back_state_t state_q;

	// level being worked on
	logic [SUM_W-1:0]        mag_q;
	logic                    neg_q;
	logic [WIDTH_W-1:0]      step_q;
	logic [IDX_W-1:0]        level_q;
	logic                    done_q;
	logic [4:0]              shift_q;
	logic [IDX_W-1:0]        col_q;

	// datapath registers
	logic [54:0]             mul_lo_q;
	logic [54:0]             mul_hi_q;
	logic [FULLW-1:0]        full_q;
	logic signed [41:0]      r_q;
	logic signed [EST_W-1:0] cur_q;
	logic [32:0]             dmag_q;
	logic                    dneg_q;
	logic [63:0]             prod_q;
	logic signed [EST_W-1:0] prev_q [MAX_LEVELS+1];

	// output register
	logic                    out_valid_q;
	logic [IDX_W-1:0]        row_q;
	logic [IDX_W-1:0]        colo_q;
	logic signed [EST_W-1:0] est_q;
	logic                    last_q;
	logic                    done_o_q;

	logic                    out_free;
	logic [SUM_W-1:0]        job_mag;
	logic [FULLW-1:0]        full_sum;
	logic [FULLW-1:0]        shifted;
	logic [40:0]             capped;
	logic signed [41:0]      r_signed;
	logic signed [32:0]      p_inc;
	logic signed [32:0]      half;
	logic signed [42:0]      row0_sum;
	logic [IDX_W-1:0]        col_dec;
	logic [RW-1:0]           prev_idx;
	logic signed [32:0]      diff;
	logic [64:0]             rnd_prod;
	logic [32:0]             corr_mag;
	logic signed [33:0]      corr;
	logic signed [34:0]      rich_sum;

	assign out_free     = !out_valid_q || out_ready;
	assign pop          = (state_q == ST_IDLE) && !queue_empty;
	assign out_valid    = out_valid_q;
	assign row_index    = row_q;
	assign column_index = colo_q;
	assign estimate     = est_q;
	assign last_of_row  = last_q;
	assign all_done     = done_o_q;

	// datapath arithmetic
	always_comb begin
		job_mag  = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : SUM_W'(job.sum);
		full_sum = {1'b0, mul_hi_q, 24'd0} + FULLW'(mul_lo_q)
			+ (FULLW'(1) << (shift_q - 5'd1));
		shifted  = full_q >> shift_q;
		capped   = (shifted > (FULLW'(1) << 40)) ? (41'(1) << 40) : shifted[40:0];
		r_signed = neg_q ? -$signed({1'b0, capped}) : $signed({1'b0, capped});
		p_inc    = 33'(prev_q[0]) + 33'sd1;
		half     = p_inc >>> 1;
		row0_sum = (level_q == '0) ? 43'(r_q) : 43'(r_q) + 43'(half);
		col_dec  = col_q - IDX_W'(1);
		prev_idx = col_dec[RW-1:0];
		diff     = 33'(cur_q) - 33'(prev_q[prev_idx]);
		rnd_prod = 65'(prod_q) + (65'(1) << 31);
		corr_mag = rnd_prod[64:32];
		corr     = dneg_q ? -$signed({1'b0, corr_mag}) : $signed({1'b0, corr_mag});
		rich_sum = 35'(cur_q) + 35'(corr);
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (!queue_empty) state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_ADD;
				ST_ADD:    state_q <= ST_SHIFT;
				ST_SHIFT:  state_q <= ST_ROW0;
				ST_ROW0:   state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free)
						state_q <= (col_q == level_q) ? ST_IDLE : ST_DIFF;
				end
				ST_DIFF:   state_q <= ST_RMUL;
				ST_RMUL:   state_q <= ST_RADD;
				ST_RADD:   state_q <= ST_EMIT;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mag_q   <= job_mag;
				neg_q   <= job.sum[SUM_W-1];
				step_q  <= job.step;
				level_q <= job.level;
				done_q  <= job.done;
				shift_q <= (job.level == '0) ? 5'd17 : 5'd16 + 5'(job.level);
				col_q   <= '0;
			end
			ST_MUL_LO: mul_lo_q <= mag_q[23:0] * step_q;
			ST_MUL_HI: mul_hi_q <= mag_q[47:24] * step_q;
			ST_ADD:    full_q <= full_sum;
			ST_SHIFT:  r_q <= r_signed;
			ST_ROW0:   cur_q <= sat32(64'(row0_sum));
			ST_EMIT: begin
				if (out_free) begin
					if (col_q == level_q)
						prev_q[col_q[RW-1:0]] <= cur_q;
					else
						col_q <= col_q + IDX_W'(1);
				end
			end
			ST_DIFF: begin
				dneg_q           <= diff[32];
				dmag_q           <= diff[32] ? 33'(-diff) : 33'(diff);
				prev_q[prev_idx] <= cur_q;
			end
			ST_RMUL:   prod_q <= dmag_q * recip_q32(col_q);
			ST_RADD:   cur_q <= sat32(64'(rich_sum));
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			row_q    <= level_q;
			colo_q   <= col_q;
			est_q    <= cur_q;
			last_q   <= (col_q == level_q);
			done_o_q <= done_q && (col_q == level_q);
		end
	end

endmodule

>>> src/romberg_integration_tableau.sv
// top level of the romberg integration tableau
// Samples are taken one per cycle while the two-entry level queue has room;
// an endpoint or a midpoint that does not close a level produces nothing. A
// sample that closes level i hands the level to the back end, which emits
// i+1 entries. Column 0 passes through the idle state, a 48 by 31 bit
// product split into two 24 by 31 bit halves, rounding, shifting, halving
// of the previous row and the output register. Each richardson column then
// passes through the difference, a 33 by 31 bit reciprocal product, rounding
// and saturation and the output register, and may wait on an output stall.
// A run of n levels takes 2^n+1 samples. The queue lets the front take the
// samples of later levels while the back end works, so a full eight-level
// run of 257 samples stays close to one sample per cycle, while a one-level
// run of three samples is bound by the back end. Values are q16.16, row
// stores hold the previous row in registers, a run restarts after the final
// level and interval_width is latched at each first endpoint.
module romberg_integration_tableau
	import rit_pkg::*;
#(
	parameter int unsigned MAX_LEVELS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write request
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [WIDTH_W-1:0] cfg_data,
	// samples
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [31:0]        s_axis_tdata,   // [31:0] sample
	// tableau entries
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,   // [3:0] row_index, [7:4] column_index,
	                                           // [39:8] estimate
	output logic               m_axis_tlast,   // last_of_row
	output logic               m_axis_tuser    // all_done
);

	logic                    queue_full;
	logic                    queue_empty;
	logic                    push;
	logic                    pop;
	rit_job_t                push_job;
	rit_job_t                pop_job;
	logic [IDX_W-1:0]        row_index;
	logic [IDX_W-1:0]        column_index;
	logic signed [EST_W-1:0] estimate;

	assign cfg_ready    = 1'b1;
	assign m_axis_tdata = {estimate, column_index, row_index};

	// accumulation and level detection
	rit_front #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (s_axis_tvalid),
		.sample       (s_axis_tdata),
		.queue_full   (queue_full),
		.sample_ready (s_axis_tready),
		.push         (push),
		.push_job     (push_job)
	);

	// finished levels waiting for the back end
	rit_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	// tableau row computation
	rit_back #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.job          (pop_job),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.row_index    (row_index),
		.column_index (column_index),
		.estimate     (estimate),
		.last_of_row  (m_axis_tlast),
		.all_done     (m_axis_tuser)
	);

endmodule
